/* rtl/core/mtec_pkg.sv */
`timescale 1ns / 1ps
package mtec_pkg;

  localparam int MODE_W = 3;
  localparam int SEQ_LEN = 6;
  localparam int HOLD_DEPTH = 5;
  localparam int NUM_ENT = 6;
  localparam int MTEC_QUEUE_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_HTML   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_XML    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WML    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCRIPT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNESC  = 3'd4;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // index 0 is the first byte out
  typedef logic [0:SEQ_LEN-1][7:0] seq_t;

  typedef struct packed {
    seq_t       bytes;
    logic [2:0] cnt;
    logic       fin;
  } mtec_entry_t;

  localparam seq_t ENT_TEXT [NUM_ENT] = '{
    "&quot;", "&nbsp;", {"&amp;", 8'h0}, {"&#39;", 8'h0},
    {"&lt;", 16'h0}, {"&gt;", 16'h0}
  };
  localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4};
  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{
    CH_DQUOTE, CH_SPACE, CH_AMP, CH_SQUOTE, CH_LT, CH_GT
  };

  // escape sequence for one byte in modes html, xml, wml and script
  function automatic mtec_entry_t esc_lookup(input logic [MODE_W-1:0] mode,
                                             input logic [7:0] b);
    mtec_entry_t r;
    r.bytes    = '0;
    r.bytes[0] = b;
    r.cnt      = 3'd1;
    r.fin      = 1'b0;
    if (mode == MODE_SCRIPT) begin
      unique case (b)
        CH_BSLASH: begin r.bytes = {"\\\\", 32'h0}; r.cnt = 3'd2; end
        CH_SQUOTE: begin r.bytes = {"\\'", 32'h0};  r.cnt = 3'd2; end
        CH_DQUOTE: begin r.bytes = {"\\\"", 32'h0}; r.cnt = 3'd2; end
        CH_LF:     begin r.bytes = {"\\n", 32'h0};  r.cnt = 3'd2; end
        CH_CR:     begin r.bytes = {"\\r", 32'h0};  r.cnt = 3'd2; end
        default:   r.cnt = 3'd1;
      endcase
    end else begin
      unique case (b)
        CH_AMP:    begin r.bytes = {"&amp;", 8'h0}; r.cnt = 3'd5; end
        CH_DQUOTE: begin r.bytes = "&quot;";        r.cnt = 3'd6; end
        CH_LT:     begin r.bytes = {"&lt;", 16'h0}; r.cnt = 3'd4; end
        CH_GT:     begin r.bytes = {"&gt;", 16'h0}; r.cnt = 3'd4; end
        CH_SQUOTE: begin
          if (mode == MODE_HTML) begin
            r.bytes = {"&#39;", 8'h0};
            r.cnt   = 3'd5;
          end else begin
            r.bytes = "&apos;";
            r.cnt   = 3'd6;
          end
        end
        CH_DOLLAR: begin
          if (mode == MODE_WML) begin
            r.bytes = {"$$", 32'h0};
            r.cnt   = 3'd2;
          end
        end
        default:   r.cnt = 3'd1;
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/core/mtec_ifs.sv */
`timescale 1ns / 1ps
interface mtec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;
  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

interface mtec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_last;
  modport source (output valid, output out_byte, output run_last, output stream_last,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_last,
                output ready);
endinterface

/* rtl/core/markup_text_escape_codec.sv */
`timescale 1ns / 1ps
// channel   dir  payload                              handshake
// in_chan   in   in_byte[8], text_end                 valid/ready
// out_chan  out  out_byte[8], run_last, stream_last   valid/ready
// cfg       in   cfg_data[3] (codec_mode)             cfg_we
//
// Each input word is classified combinationally; its 1..6 output bytes are queued
// as one entry, and a word that yields no bytes queues nothing. The back end emits
// one byte per cycle while the output is not stalled. Input stalls only when the
// entry queue is full. Output is registered; a stalled output holds its word. Reset
// is synchronous, active low, clears mode, held count, queue and output valid.
module markup_text_escape_codec
  import mtec_pkg::*;
#(
  parameter int QUEUE_DEPTH = MTEC_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  mtec_in_if.sink           in_chan,
  mtec_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_data
);

  logic        q_ready;
  logic        push;
  mtec_entry_t push_entry;
  logic        pop;
  logic        head_valid;
  mtec_entry_t head;

  mtec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .q_ready  (q_ready),
    .push     (push),
    .entry    (push_entry)
  );

  mtec_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mtec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

/* rtl/core/mtec_front.sv */
`timescale 1ns / 1ps
module mtec_front
  import mtec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_data,
  mtec_in_if.sink           in_chan,
  input  logic              q_ready,
  output logic              push,
  output mtec_entry_t       entry
);

  logic [MODE_W-1:0] mode_r;
  logic [7:0]        held_r [HOLD_DEPTH];
  logic [2:0]        hcnt_r;
  logic [7:0]        held_nxt [HOLD_DEPTH];
  logic [2:0]        hcnt_nxt;
  logic              accept;

  assign in_chan.ready = q_ready;
  assign accept = in_chan.valid && q_ready;

  always_comb begin
    logic [7:0]  b;
    mtec_entry_t a;
    logic        full_hit;
    logic        pre_hit;
    logic        pmatch;
    logic [7:0]  full_char;
    logic [2:0]  m;
    b         = in_chan.in_byte;
    a.bytes   = '0;
    a.cnt     = 3'd0;
    a.fin     = in_chan.text_end;
    full_hit  = 1'b0;
    pre_hit   = 1'b0;
    full_char = 8'h0;
    m         = hcnt_r + 3'd1;
    held_nxt  = held_r;
    hcnt_nxt  = hcnt_r;
    for (int e = 0; e < NUM_ENT; e++) begin
      pmatch = (ENT_TEXT[e][hcnt_r] == b);
      for (int j = 0; j < HOLD_DEPTH; j++) begin
        if ((3'(j) < hcnt_r) && (held_r[j] != ENT_TEXT[e][j])) pmatch = 1'b0;
      end
      if (pmatch && (m == ENT_LEN[e])) begin
        full_hit  = 1'b1;
        full_char = ENT_CHAR[e];
      end
      if (pmatch && (m < ENT_LEN[e])) pre_hit = 1'b1;
    end

    if (mode_r == MODE_UNESC) begin
      if (hcnt_r == 3'd0) begin
        if (b == CH_AMP) begin
          held_nxt[0] = b;
          hcnt_nxt    = 3'd1;
        end else begin
          a.bytes[0] = b;
          a.cnt      = 3'd1;
        end
      end else if (full_hit) begin
        a.bytes[0] = full_char;
        a.cnt      = 3'd1;
        hcnt_nxt   = 3'd0;
      end else if (pre_hit) begin
        for (int j = 0; j < HOLD_DEPTH; j++) begin
          if (3'(j) == hcnt_r) held_nxt[j] = b;
        end
        hcnt_nxt = m;
      end else begin
        // broken entity: release held bytes, an ampersand starts a new hold
        for (int j = 0; j < SEQ_LEN; j++) a.bytes[j] = b;
        for (int j = 0; j < HOLD_DEPTH; j++) begin
          if (3'(j) < hcnt_r) a.bytes[j] = held_r[j];
        end
        if (b == CH_AMP) begin
          a.cnt       = hcnt_r;
          held_nxt[0] = CH_AMP;
          hcnt_nxt    = 3'd1;
        end else begin
          a.cnt    = m;
          hcnt_nxt = 3'd0;
        end
      end
    end else if (mode_r <= MODE_SCRIPT) begin
      a     = esc_lookup(mode_r, b);
      a.fin = in_chan.text_end;
    end else begin
      a.bytes[0] = b;
      a.cnt      = 3'd1;
    end

    // end of text: append whatever is still held
    if (in_chan.text_end) begin
      for (int i = 0; i < SEQ_LEN; i++) begin
        for (int k = 0; k < HOLD_DEPTH; k++) begin
          if ((3'(k) < hcnt_nxt) && ((a.cnt + 3'(k)) == 3'(i))) a.bytes[i] = held_nxt[k];
        end
      end
      a.cnt    = a.cnt + hcnt_nxt;
      hcnt_nxt = 3'd0;
    end
    entry = a;
  end

  assign push = accept && (entry.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HTML;
      hcnt_r <= 3'd0;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
      hcnt_r <= 3'd0;
    end else if (accept) begin
      hcnt_r <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

endmodule

/* rtl/core/mtec_queue.sv */
`timescale 1ns / 1ps
module mtec_queue
  import mtec_pkg::*;
#(
  parameter int QUEUE_DEPTH = MTEC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mtec_entry_t push_entry,
  output logic        not_full,
  input  logic        pop,
  output logic        head_valid,
  output mtec_entry_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  mtec_entry_t   mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_pop;

  assign not_full   = (count_r != CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_entry;
  end

endmodule

/* rtl/core/mtec_back.sv */
`timescale 1ns / 1ps
module mtec_back
  import mtec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  mtec_entry_t head,
  output logic        pop,
  mtec_out_if.source  out_chan
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       stream_last_r;
  logic [2:0] pos_r;
  logic       load;
  logic       last;

  assign load = !out_valid_r || out_chan.ready;
  assign last = (pos_r == head.cnt - 3'd1);
  assign pop  = load && head_valid && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 3'd0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) pos_r <= last ? 3'd0 : pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte_r    <= head.bytes[pos_r];
      run_last_r    <= last;
      stream_last_r <= last && head.fin;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.run_last    = run_last_r;
  assign out_chan.stream_last = stream_last_r;

endmodule

/* rtl/core/mtec_checker.sv */
`timescale 1ns / 1ps
module mtec_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_stream_last
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_run_last) && $stable(out_stream_last))
    else $error("output word changed while stalled");

  // end of stream is always end of a run
  a_stream_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_last |-> out_run_last)
    else $error("stream_last without run_last");

  // input backpressure only while output has a word pending
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with idle output");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind markup_text_escape_codec mtec_checker u_mtec_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_byte        (out_chan.out_byte),
  .out_run_last    (out_chan.run_last),
  .out_stream_last (out_chan.stream_last)
);
